/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and quiet during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// A trigger that must be met by a consequence at the same edge.
`define ASSERT_IMPLY(lbl, trig, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cons)) else $error(msg);

`endif

/* rtl/b64d_pkg.sv */
// ----------------------------------------------------------------------------
// b64d_pkg
// Types, constants and the character table shared by the base64 decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

	// Width of the per-message byte counter.
	localparam int COUNT_WIDTH = 16;
	// Depth of the command queue between the front and the back.
	localparam int CMD_DEPTH = 4;
	localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
	localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

	// Special characters.
	localparam logic [7:0] CHAR_PAD   = 8'h3D;
	localparam logic [7:0] CHAR_PLUS  = 8'h2B;
	localparam logic [7:0] CHAR_SLASH = 8'h2F;

	// Result status codes.
	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_ILLEGAL = 2'd1;
	localparam logic [1:0] STATUS_TRUNC   = 2'd2;

	// Message run mode.
	typedef enum logic [1:0] {
		MODE_DECODE = 2'd0,
		MODE_LIMIT  = 2'd1,
		MODE_ERROR  = 2'd2
	} run_mode_t;

	// Kind of work handed from the front to the back.
	typedef enum logic {
		CMD_BYTES  = 1'b0,
		CMD_STATUS = 1'b1
	} cmd_kind_t;

	typedef struct packed {
		logic [7:0] in_char;
		logic       is_last;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic [1:0] status;
		logic       last;
	} out_item_t;

	// One command: either a group of up to three bytes or a single status item.
	typedef struct packed {
		cmd_kind_t   kind;
		logic [23:0] word;
		logic [1:0]  count;
		logic [1:0]  status;
		logic        last;
	} cmd_t;

	// Command queue status seen by the front and the back.
	typedef struct packed {
		logic full;
		logic avail;
	} cmdq_stat_t;

	// Character to sextet; bit 6 set marks an illegal character.
	function automatic logic [6:0] sextet_of(input logic [7:0] c);
		logic [6:0] r;
		r = 7'h40;
		if (c >= 8'h41 && c <= 8'h5A) begin
			r = {1'b0, 6'(c - 8'h41)};
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			r = {1'b0, 6'(c - 8'h61 + 8'd26)};
		end else if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b0, 6'(c - 8'h30 + 8'd52)};
		end else if (c == CHAR_PLUS) begin
			r = 7'd62;
		end else if (c == CHAR_SLASH) begin
			r = 7'd63;
		end else if (c == CHAR_PAD) begin
			r = 7'd0;
		end
		return r;
	endfunction

	// Byte limit loaded into the counter, saturated to the counter's range.
	function automatic logic [COUNT_WIDTH-1:0] load_limit(input logic [15:0] v);
		logic [31:0] wide;
		logic [31:0] cmax;
		wide = {16'd0, v};
		cmax = (32'd1 << COUNT_WIDTH) - 32'd1;
		if (wide > cmax) begin
			return cmax[COUNT_WIDTH-1:0];
		end
		return wide[COUNT_WIDTH-1:0];
	endfunction

endpackage

/* rtl/b64d_front.sv */
// ----------------------------------------------------------------------------
// b64d_front
// Accepts characters, tracks group and limit state, and issues commands.
// ----------------------------------------------------------------------------
module b64d_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [15:0]          cfg_data,
	input  logic                 accept,
	input  b64d_pkg::in_item_t   item,
	output logic                 cmd_push,
	output b64d_pkg::cmd_t       cmd
);

	logic [15:0]                       byte_limit_q;
	logic [1:0]                        group_pos_q;
	logic [17:0]                       held_q;
	logic                              third_pad_q;
	logic [b64d_pkg::COUNT_WIDTH-1:0]  bytes_left_q;
	logic                              msg_start_q;
	b64d_pkg::run_mode_t               mode_q;

	logic [1:0]                        group_pos_d;
	logic [17:0]                       held_d;
	logic                              third_pad_d;
	logic [b64d_pkg::COUNT_WIDTH-1:0]  bytes_left_d;
	b64d_pkg::run_mode_t               mode_d;
	logic [b64d_pkg::COUNT_WIDTH-1:0]  left;
	logic [6:0]                        sx;
	logic                              is_pad;
	logic [1:0]                        cnt;

	// The limit register takes every write.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_limit_q <= 16'hFFFF;
		end else if (cfg_valid) begin
			byte_limit_q <= cfg_data;
		end
	end

	// Per-character decode step.
	always_comb begin
		sx           = b64d_pkg::sextet_of(item.in_char);
		is_pad       = (item.in_char == b64d_pkg::CHAR_PAD);
		left         = msg_start_q ? b64d_pkg::load_limit(byte_limit_q) : bytes_left_q;
		mode_d       = mode_q;
		group_pos_d  = group_pos_q;
		held_d       = held_q;
		third_pad_d  = third_pad_q;
		bytes_left_d = left;
		cnt          = 2'd3;
		cmd_push     = 1'b0;
		cmd.kind     = b64d_pkg::CMD_STATUS;
		cmd.word     = {held_q, sx[5:0]};
		cmd.count    = 2'd1;
		cmd.status   = b64d_pkg::STATUS_OK;
		cmd.last     = item.is_last;

		if (mode_q == b64d_pkg::MODE_DECODE && group_pos_q == 2'd0
				&& left == '0) begin
			mode_d = b64d_pkg::MODE_LIMIT;
		end

		case (mode_d)
			b64d_pkg::MODE_DECODE: begin
				if (sx[6]) begin
					cmd_push   = 1'b1;
					cmd.status = b64d_pkg::STATUS_ILLEGAL;
					cmd.last   = 1'b1;
					mode_d     = b64d_pkg::MODE_ERROR;
				end else if (group_pos_q != 2'd3) begin
					held_d = {held_q[11:0], sx[5:0]};
					if (group_pos_q == 2'd2) begin
						third_pad_d = is_pad;
					end
					group_pos_d = group_pos_q + 2'd1;
					if (item.is_last) begin
						cmd_push   = 1'b1;
						cmd.status = b64d_pkg::STATUS_TRUNC;
					end
				end else begin
					if (third_pad_q) begin
						cnt = 2'd1;
					end else if (is_pad) begin
						cnt = 2'd2;
					end
					if ({{(b64d_pkg::COUNT_WIDTH-2){1'b0}}, cnt} > left) begin
						cnt = left[1:0];
					end
					bytes_left_d = left - {{(b64d_pkg::COUNT_WIDTH-2){1'b0}}, cnt};
					cmd_push     = 1'b1;
					cmd.kind     = b64d_pkg::CMD_BYTES;
					cmd.count    = cnt;
					group_pos_d  = 2'd0;
					held_d       = '0;
					third_pad_d  = 1'b0;
				end
			end
			b64d_pkg::MODE_LIMIT: begin
				cmd_push = item.is_last;
			end
			default: begin
				cmd_push = 1'b0;
			end
		endcase

		cmd_push = cmd_push && accept;
	end

	// Message state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_pos_q  <= 2'd0;
			held_q       <= '0;
			third_pad_q  <= 1'b0;
			bytes_left_q <= '0;
			msg_start_q  <= 1'b1;
			mode_q       <= b64d_pkg::MODE_DECODE;
		end else if (accept) begin
			bytes_left_q <= bytes_left_d;
			if (item.is_last) begin
				group_pos_q <= 2'd0;
				held_q      <= '0;
				third_pad_q <= 1'b0;
				msg_start_q <= 1'b1;
				mode_q      <= b64d_pkg::MODE_DECODE;
			end else begin
				group_pos_q <= group_pos_d;
				held_q      <= held_d;
				third_pad_q <= third_pad_d;
				msg_start_q <= 1'b0;
				mode_q      <= mode_d;
			end
		end
	end

endmodule

/* rtl/b64d_cmd_fifo.sv */
// ----------------------------------------------------------------------------
// b64d_cmd_fifo
// Short command queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module b64d_cmd_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  b64d_pkg::cmd_t       wdata,
	input  logic                 pop,
	output b64d_pkg::cmd_t       rdata,
	output b64d_pkg::cmdq_stat_t stat
);

	b64d_pkg::cmd_t                   mem_q [b64d_pkg::CMD_DEPTH];
	logic [b64d_pkg::CMD_PTR_W-1:0]   wr_ptr_q;
	logic [b64d_pkg::CMD_PTR_W-1:0]   rd_ptr_q;
	logic [b64d_pkg::CMD_CNT_W-1:0]   count_q;

	assign rdata      = mem_q[rd_ptr_q];
	assign stat.full  = (count_q == b64d_pkg::CMD_CNT_W'(b64d_pkg::CMD_DEPTH));
	assign stat.avail = (count_q != '0);

	// Storage is written at the tail only.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* rtl/b64d_back.sv */
// ----------------------------------------------------------------------------
// b64d_back
// Expands queued commands into result items, one per cycle while the result side pops, into a register.
// ----------------------------------------------------------------------------
module b64d_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  b64d_pkg::cmd_t       head,
	input  b64d_pkg::cmdq_stat_t qstat,
	output logic                 cmd_pop,
	input  logic                 pop,
	output logic                 empty,
	output b64d_pkg::out_item_t  result
);

	logic [1:0]              idx_q;
	logic                    out_valid_q;
	b64d_pkg::out_item_t     out_q;
	logic                    load;
	logic                    final_one;
	b64d_pkg::out_item_t     next;

	assign empty  = !out_valid_q;
	assign result = out_q;

	// Build the next result from the head command.
	always_comb begin
		load      = qstat.avail && (!out_valid_q || pop);
		final_one = (head.kind == b64d_pkg::CMD_STATUS) || ((idx_q + 2'd1) == head.count);
		cmd_pop   = load && final_one;
		next.byte_valid = (head.kind == b64d_pkg::CMD_BYTES);
		next.status     = head.status;
		next.last       = head.last && final_one;
		case (idx_q)
			2'd0:    next.out_byte = head.word[23:16];
			2'd1:    next.out_byte = head.word[15:8];
			default: next.out_byte = head.word[7:0];
		endcase
		if (head.kind == b64d_pkg::CMD_STATUS) begin
			next.out_byte = 8'd0;
		end
	end

	// Output register holds its item until it is popped.
	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= 2'd0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= final_one ? 2'd0 : idx_q + 2'd1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* rtl/base64_decoder_checked.sv */
// ----------------------------------------------------------------------------
// base64_decoder_checked
// Base64 body decoder with byte limit, illegal-character and truncation checks.
// ----------------------------------------------------------------------------
// The decoder takes one character per cycle: a character is accepted whenever
// full is low, so a steady stream runs at one item per clock. Each complete
// group of four characters yields up to three byte items, which leave one per
// clock from the output register while pop stays high, so a stream of full
// groups yields three result items for every four characters and the result
// side keeps up. The four-entry command queue between the decoding front and
// the expanding back absorbs stalls on the result side; full rises only once
// the queue holds four commands while the output register waits, which takes
// a result side held off for several groups. A result passes from the accepted
// character through the command queue and then the output register to the
// result ports. The byte limit register is always ready and takes effect at
// the first character of the next message.

`include "assert_macros.svh"

module base64_decoder_checked (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [15:0]          cfg_data,
	input  logic                 push,
	output logic                 full,
	input  b64d_pkg::in_item_t   item,
	output logic                 empty,
	input  logic                 pop,
	output b64d_pkg::out_item_t  result
);

	logic                 accept;
	logic                 cmd_push;
	logic                 cmd_pop;
	b64d_pkg::cmd_t       cmd_in;
	b64d_pkg::cmd_t       cmd_head;
	b64d_pkg::cmdq_stat_t qstat;

	assign full   = qstat.full;
	assign accept = push && !qstat.full;

	b64d_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.item      (item),
		.cmd_push  (cmd_push),
		.cmd       (cmd_in)
	);

	b64d_cmd_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.wdata  (cmd_in),
		.pop    (cmd_pop),
		.rdata  (cmd_head),
		.stat   (qstat)
	);

	b64d_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (cmd_head),
		.qstat   (qstat),
		.cmd_pop (cmd_pop),
		.pop     (pop),
		.empty   (empty),
		.result  (result)
	);

	// A full queue always has a command for the back to work on.
	`ASSERT_IMPLY(a_full_has_work, qstat.full, qstat.avail, "full queue shows no command")
	// The back only removes commands that are there.
	`ASSERT_IMPLY(a_pop_nonempty, cmd_pop, qstat.avail, "command removed from empty queue")
	// An item without a byte carries a zero byte.
	`ASSERT_IMPLY(a_zero_byte, !empty && !result.byte_valid, result.out_byte == 8'd0, "stray byte")
	// Error items always close the message.
	`ASSERT_IMPLY(a_err_last, !empty && result.status != b64d_pkg::STATUS_OK, result.last, "error not last")

endmodule

/* tb/base64_decoder_checked_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// base64_decoder_checked_test
// Self-checking bench for the base64 body decoder. Characters are pushed in
// as directed messages and then as random messages: well-formed groups,
// padded tails, truncated and illegal messages and raw noise. Phases run
// under a range of byte limits. A scoreboard decodes every accepted item and
// checks each popped result in order. Both sides idle at random, and the
// result side also holds off long enough for the decoder to stall its input.
// ----------------------------------------------------------------------------
module base64_decoder_checked_test;

	localparam int    SETTLE_CYCLES = 12;
	localparam int    IDLE_LIMIT    = 2000;
	localparam int    RANDOM_CHARS  = 300;
	localparam int    PHASE_CHARS   = 45;
	localparam string B64_ALPHABET  =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

	// Decoding scoreboard: mirrors the decoder state and holds the results owed.
	class b64_tracker;
		logic [15:0]                      byte_limit;
		logic [1:0]                       grp_pos;
		logic [17:0]                      held;
		bit                               third_pad;
		logic [b64d_pkg::COUNT_WIDTH-1:0] bytes_left;
		bit                               msg_start;
		b64d_pkg::run_mode_t              mode;
		b64d_pkg::out_item_t              owed[$];
		int                               errors;
		int                               accepted;

		function new();
			byte_limit = 16'hFFFF;
			bytes_left = '0;
			errors     = 0;
			accepted   = 0;
			end_message();
		endfunction

		function void end_message();
			grp_pos   = '0;
			held      = '0;
			third_pad = 1'b0;
			msg_start = 1'b1;
			mode      = b64d_pkg::MODE_DECODE;
		endfunction

		function void set_limit(logic [15:0] v);
			byte_limit = v;
		endfunction

		// Value of a base64 character, or -1 where the character is not legal.
		static function int sextet_value(logic [7:0] c);
			if (c >= "A" && c <= "Z") begin
				return int'(c) - int'("A");
			end
			if (c >= "a" && c <= "z") begin
				return int'(c) - int'("a") + 26;
			end
			if (c >= "0" && c <= "9") begin
				return int'(c) - int'("0") + 52;
			end
			if (c == b64d_pkg::CHAR_PLUS) begin
				return 62;
			end
			if (c == b64d_pkg::CHAR_SLASH) begin
				return 63;
			end
			if (c == b64d_pkg::CHAR_PAD) begin
				return 0;
			end
			return -1;
		endfunction

		function void owe(logic [7:0] b, logic v, logic [1:0] st, logic l);
			b64d_pkg::out_item_t r;
			r.out_byte   = b;
			r.byte_valid = v;
			r.status     = st;
			r.last       = l;
			owed = {owed, r};
		endfunction

		// Note one accepted character and queue whatever results it causes.
		function void take_char(b64d_pkg::in_item_t it);
			longint     cmax;
			int         v;
			int         cnt;
			logic [23:0] word;
			accepted++;
			cmax = (64'd1 << b64d_pkg::COUNT_WIDTH) - 1;
			if (msg_start) begin
				bytes_left = (longint'(byte_limit) > cmax)
					? cmax[b64d_pkg::COUNT_WIDTH-1:0]
					: byte_limit[b64d_pkg::COUNT_WIDTH-1:0];
				msg_start = 1'b0;
			end
			// A spent limit is only noticed on the first character of a group.
			if (mode == b64d_pkg::MODE_DECODE && grp_pos == 0 && bytes_left == 0) begin
				mode = b64d_pkg::MODE_LIMIT;
			end
			if (mode == b64d_pkg::MODE_DECODE) begin
				v = sextet_value(it.in_char);
				if (v < 0) begin
					owe(8'h00, 1'b0, b64d_pkg::STATUS_ILLEGAL, 1'b1);
					mode = b64d_pkg::MODE_ERROR;
				end else if (grp_pos < 3) begin
					held = {held[11:0], 6'(v)};
					if (grp_pos == 2) begin
						third_pad = (it.in_char == b64d_pkg::CHAR_PAD);
					end
					grp_pos++;
					if (it.is_last) begin
						owe(8'h00, 1'b0, b64d_pkg::STATUS_TRUNC, 1'b1);
					end
				end else begin
					word = {held, 6'(v)};
					cnt  = third_pad ? 1 : ((it.in_char == b64d_pkg::CHAR_PAD) ? 2 : 3);
					if (cnt > bytes_left) begin
						cnt = int'(bytes_left);
					end
					for (int i = 0; i < cnt; i++) begin
						owe(word[23 - 8 * i -: 8], 1'b1, b64d_pkg::STATUS_OK,
							it.is_last && (i == cnt - 1));
					end
					bytes_left = bytes_left - b64d_pkg::COUNT_WIDTH'(cnt);
					grp_pos    = '0;
					held       = '0;
					third_pad  = 1'b0;
				end
			end else if (mode == b64d_pkg::MODE_LIMIT) begin
				if (it.is_last) begin
					owe(8'h00, 1'b0, b64d_pkg::STATUS_OK, 1'b1);
				end
			end
			if (it.is_last) begin
				end_message();
			end
		endfunction

		// Compare one popped result with the oldest one owed.
		function void match_result(b64d_pkg::out_item_t got);
			b64d_pkg::out_item_t want;
			if (owed.size() == 0) begin
				errors++;
				$display("%0t: result with none expected, ", $time,
					"got byte %h valid %b status %0d last %b",
					got.out_byte, got.byte_valid, got.status, got.last);
				return;
			end
			want = owed.pop_front();
			if (got.out_byte !== want.out_byte || got.byte_valid !== want.byte_valid ||
				got.status !== want.status || got.last !== want.last) begin
				errors++;
				$display("%0t: expected byte %h valid %b status %0d last %b, ", $time,
					want.out_byte, want.byte_valid, want.status, want.last,
					"got byte %h valid %b status %0d last %b",
					got.out_byte, got.byte_valid, got.status, got.last);
			end
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [15:0]         cfg_data;
	logic                push;
	logic                full;
	b64d_pkg::in_item_t  item;
	logic                empty;
	logic                pop;
	b64d_pkg::out_item_t result;

	b64_tracker  tracker;
	bit          gaps_on;
	int          rx_hold_req;
	int          sent_in_phase;

	base64_decoder_checked dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.push      (push),
		.full      (full),
		.item      (item),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Result side: pops with random idling, plus any long hold-off requested.
	initial begin
		int hold_left;
		hold_left = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (rx_hold_req > 0) begin
				hold_left   = rx_hold_req;
				rx_hold_req = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				pop <= gaps_on ? ($urandom_range(0, 99) >= 9) : 1'b1;
			end
			@(posedge clk);
			if (pop && !empty) begin
				tracker.match_result(result);
			end
		end
	end

	// Watchdog: ends the run when no item has moved for too long.
	initial begin
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
			if (quiet >= IDLE_LIMIT) begin
				$display("base64_decoder_checked_test NOT OK");
				$finish;
			end
		end
	end

	function automatic logic [7:0] random_b64_char();
		if ($urandom_range(0, 99) < 4) begin
			return b64d_pkg::CHAR_PAD;
		end
		return B64_ALPHABET[$urandom_range(0, 63)];
	endfunction

	function automatic logic [7:0] random_bad_char();
		logic [7:0] c;
		do begin
			c = 8'($urandom_range(0, 255));
		end while (b64_tracker::sextet_value(c) >= 0);
		return c;
	endfunction

	// Offer one character and wait until the decoder takes it. Push stays high
	// afterwards, so the next call or the settle task must follow at once.
	task automatic send_char(input logic [7:0] c, input bit l);
		b64d_pkg::in_item_t it;
		it.in_char = c;
		it.is_last = l;
		@(negedge clk);
		while (gaps_on && $urandom_range(0, 99) < 9) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		item <= it;
		do begin
			@(posedge clk);
		end while (full);
		tracker.take_char(it);
		sent_in_phase++;
	endtask

	task automatic send_text(input string s, input bit end_last);
		for (int i = 0; i < s.len(); i++) begin
			send_char(s[i], end_last && (i == s.len() - 1));
		end
	endtask

	// Stop sending and wait until every owed result has been popped.
	task automatic settle();
		@(negedge clk);
		push <= 1'b0;
		while (tracker.owed.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_limit(input logic [15:0] v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		tracker.set_limit(v);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// One random message: mostly whole groups, some truncated, illegal or noise.
	task automatic send_random_message();
		logic [7:0] body[$];
		int         roll;
		int         groups;
		int         k;
		roll   = $urandom_range(0, 99);
		groups = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 10) : $urandom_range(1, 3);
		for (int g = 0; g < groups * 4; g++) begin
			body = {body, random_b64_char()};
		end
		if (roll < 70) begin
			k = $urandom_range(0, 3);
			if (k >= 1) begin
				body[body.size() - 1] = b64d_pkg::CHAR_PAD;
			end
			if (k == 2) begin
				body[body.size() - 2] = b64d_pkg::CHAR_PAD;
			end
		end else if (roll < 85) begin
			k = $urandom_range(1, 3);
			repeat (k) void'(body.pop_back());
		end else if (roll < 95) begin
			body[$urandom_range(0, body.size() - 1)] = random_bad_char();
		end else begin
			foreach (body[i]) begin
				body[i] = 8'($urandom_range(0, 255));
			end
		end
		foreach (body[i]) begin
			send_char(body[i], i == body.size() - 1);
		end
	endtask

	// Main sequence.
	initial begin
		int          phase;
		int          start_count;
		logic [15:0] lim;
		tracker     = new();
		arst_n      = 1'b0;
		cfg_valid   = 1'b0;
		cfg_data    = '0;
		push        = 1'b0;
		item        = '0;
		pop         = 1'b0;
		gaps_on     = 1'b1;
		rx_hold_req = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed messages under the reset limit.
		send_text("TWFu", 1'b0);
		send_text("QUI=", 1'b1);
		send_text("QQ==", 1'b1);
		send_text("=A", 1'b1);
		send_char(8'h00, 1'b1);
		send_text("AZaz09+/", 1'b1);
		// A limit written mid-message only applies from the next message.
		send_text("TW", 1'b0);
		settle();
		write_limit(16'd2);
		send_text("Fu", 1'b1);
		send_text("TWFuTW", 1'b1);
		// With a zero limit nothing is examined, not even a bad character.
		settle();
		write_limit(16'd0);
		send_char("Z", 1'b0);
		send_char(8'hFF, 1'b1);
		settle();
		write_limit(16'hFFFF);

		// Result side holds off while a long message fills the decoder.
		rx_hold_req = 80;
		for (int g = 0; g < 40; g++) begin
			send_char(random_b64_char(), g == 39);
		end
		settle();

		// Random phases, each under its own byte limit.
		start_count = tracker.accepted;
		phase = 0;
		while (tracker.accepted - start_count < RANDOM_CHARS) begin
			case (phase % 8)
				0:       lim = 16'd0;
				1:       lim = 16'd1;
				2:       lim = 16'd2;
				3:       lim = 16'($urandom_range(3, 12));
				4:       lim = 16'hFFFF;
				5:       lim = 16'($urandom_range(0, 16'hFFFF));
				6:       lim = 16'($urandom_range(4, 30));
				default: lim = 16'hFFFF;
			endcase
			gaps_on = (phase % 8 != 4);
			write_limit(lim);
			sent_in_phase = 0;
			while (sent_in_phase < PHASE_CHARS &&
				tracker.accepted - start_count < RANDOM_CHARS) begin
				send_random_message();
			end
			settle();
			phase++;
		end
		gaps_on = 1'b1;
		write_limit(16'hFFFF);

		if (tracker.errors == 0 && tracker.owed.size() == 0) begin
			$display("base64_decoder_checked_test OK");
		end else begin
			$display("base64_decoder_checked_test NOT OK");
		end
		$finish;
	end

endmodule
